/* rtl/core/twm_pkg.sv */
package twm_pkg;

  // Field widths of the block's ports and state
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned WIN_W   = 21;
  localparam int unsigned SUM_W   = 52;
  localparam int unsigned POS_W   = 40;
  localparam int unsigned MEAN_W  = 48;

  // Parameter defaults
  localparam int unsigned DEPTH_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Window length limits and reset value
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10000);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(1048576);

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_WINDOW = 1'b0;

  // One closed window, handed from front to back
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] sum;
    logic [WIN_W-1:0] count;
  } twm_job_t;

endpackage

/* rtl/core/twm_front.sv */
module twm_front
  import twm_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WIN_W-1:0]   window_length_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DEPTH_W-1:0] depth_value_i,
  input  logic               new_sequence_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output twm_job_t           job_o
);

  logic [SUM_W-1:0] sum_q, sum_base, sum_nx;
  logic [WIN_W-1:0] fill_q, fill_base, fill_nx, w_eff;
  logic [POS_W-1:0] pos_q, pos_base, pos_nx;
  logic             accept, close;

  always_comb begin
    if (window_length_i == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_length_i > WIN_MAX) begin
      w_eff = WIN_MAX;
    end else begin
      w_eff = window_length_i;
    end
    sum_base  = new_sequence_i ? '0 : sum_q;
    fill_base = new_sequence_i ? '0 : fill_q;
    pos_base  = new_sequence_i ? '0 : pos_q;
    // position saturates at all ones
    pos_nx    = (pos_base != '1) ? pos_base + POS_W'(1) : pos_base;
    sum_nx    = sum_base + SUM_W'(depth_value_i[DEPTH_BITS-1:0]);
    fill_nx   = fill_base + WIN_W'(1);
    close     = (fill_nx >= w_eff);
  end

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = accept && close;
  assign job_o       = '{pos: pos_nx, sum: sum_nx, count: fill_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
    end else if (accept) begin
      pos_q <= pos_nx;
      if (close) begin
        sum_q  <= '0;
        fill_q <= '0;
      end else begin
        sum_q  <= sum_nx;
        fill_q <= fill_nx;
      end
    end
  end

endmodule

/* rtl/core/twm_queue.sv */
module twm_queue
  import twm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  twm_job_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output twm_job_t pop_data_o
);

  twm_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // front only pushes a closed window into free space
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_valid_i |-> push_ready_o)
    else $error("window pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

/* rtl/core/twm_back.sv */
module twm_back
  import twm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  twm_job_t          job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [POS_W-1:0]  end_position_o,
  output logic [MEAN_W-1:0] window_mean_o
);

  localparam int unsigned NUM_W  = SUM_W + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  num_q;      // numerator in, quotient out
  logic [WIN_W-1:0]  rem_q, den_q;
  logic [POS_W-1:0]  pos_q;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [MEAN_W-1:0] out_mean_q;

  logic [WIN_W:0]    rem_sh, rem_sub;
  logic              q_bit, out_load, sat;
  logic [MEAN_W-1:0] mean;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = (rem_sh >= {1'b0, den_q});
  end

  assign sat  = |num_q[NUM_W-1:MEAN_W];
  assign mean = sat ? '1 : num_q[MEAN_W-1:0];

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (job_valid_i) state_d = ST_DIV;
      ST_DIV:  if (step_q == '0) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      num_q <= NUM_W'(job_i.sum) << FRAC_BITS;
      den_q <= job_i.count;
      pos_q <= job_i.pos;
      rem_q <= '0;
    end else if (state_q == ST_DIV && step_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
    end
    if (out_load) begin
      out_pos_q  <= pos_q;
      out_mean_q <= mean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && job_valid_i) begin
        step_q <= STEP_W'(NUM_W);
      end else if (state_q == ST_DIV && step_q != '0) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign end_position_o = out_pos_q;
  assign window_mean_o  = out_mean_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == ST_DIV) |-> den_q != '0)
    else $error("division by empty window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE && $past(step_q) == '0)
    else $error("result shown before division finished");
`endif

endmodule

/* rtl/core/tumbling_window_mean_top.sv */
// Path: a window-closing beat is pushed into the queue and popped by the back part when it is idle;
//   it then runs 52+FRAC_BITS radix-2 divider steps and registers the result at the output.
// Throughput: one beat per cycle while the queue has space; a full queue drops in_ready_o,
//   so short windows are paced by the back part, one division at a time, and by out_ready_i.
// Reset: rst_ni is asynchronous, active low; sums, counts and queue clear, window length 10000.
module tumbling_window_mean_top
  import twm_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB-style configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // depth samples in
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DEPTH_W-1:0]    depth_value_i,
  input  logic                  new_sequence_i,
  // window results out
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      end_position_o,
  output logic [MEAN_W-1:0]     window_mean_o
);

  // Register map: window_length at byte 0; word index is paddr[2].
  logic [WIN_W-1:0] window_length_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WIN_RESET;
    end else if (cfg_wr) begin
      window_length_q <= pwdata[WIN_W-1:0];
    end
  end

  // reads ignore the byte offset; unmapped word reads as zero
  assign prdata = (paddr[2] == REG_WINDOW) ? CFG_DATA_W'(window_length_q) : '0;

  // Front accumulates every beat; back divides closed windows.
  twm_job_t push_job, pop_job;
  logic     push_valid, push_ready, pop_valid, pop_ready;

  twm_front #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_length_i (window_length_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .depth_value_i   (depth_value_i),
    .new_sequence_i  (new_sequence_i),
    .job_valid_o     (push_valid),
    .job_ready_i     (push_ready),
    .job_o           (push_job)
  );

  // Short queue so accumulation carries on during a division.
  twm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  twm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (pop_valid),
    .job_ready_o    (pop_ready),
    .job_i          (pop_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .end_position_o (end_position_o),
    .window_mean_o  (window_mean_o)
  );

endmodule
